>>> hw/rtl/tlcr_pkg.sv
// Shared types, constants and helpers of the text line cell renderer.
`default_nettype none

package tlcr_pkg;

    localparam int COLUMNS_RESET     = 80;
    localparam int TAB_WIDTH_DEFAULT = 8;
    localparam int CUR_W             = 14;
    localparam int CMD_DEPTH         = 2;
    localparam int MOD_STEPS         = 2;

    localparam logic signed [CUR_W-1:0] CUR_MAX = 14'sd8191;

    // input op codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // result kinds
    localparam logic KIND_CELL = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_CARET_XOR = 8'h40;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [11:0] scroll_offset;
        logic        mark_left;
    } t_in;

    typedef struct packed {
        logic       kind;
        logic [7:0] column;
        logic [7:0] cell_char;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_CHARS = 2'd1,
        CMD_TAB   = 2'd2,
        CMD_END   = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind       kind;
        logic [3:0][7:0] chars;     // chars[0] goes out first
        logic [1:0]      last_idx;
        logic [11:0]     offset;
        logic            mark;
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] r;
        begin
            if (nib < 4'd10) begin
                r = 8'h30 + {4'd0, nib};
            end else begin
                r = 8'h37 + {4'd0, nib};
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tlcr_front.sv
// Front end: accepts input beats and turns them into cell-sequence commands.
`default_nettype none

module tlcr_front (
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire tlcr_pkg::t_in i_in_data,
    input  wire logic          i_q_full,
    output logic               o_push,
    output tlcr_pkg::t_cmd     o_cmd
);

    logic          take;
    logic          keep;
    tlcr_pkg::t_cmd cmd;

    assign o_in_ready = !i_q_full;
    assign take       = i_in_valid && !i_q_full;
    assign o_push     = take && keep;
    assign o_cmd      = cmd;

    always_comb begin
        cmd          = '0;
        cmd.kind     = tlcr_pkg::CMD_START;
        cmd.offset   = i_in_data.scroll_offset;
        cmd.mark     = i_in_data.mark_left;
        cmd.chars[0] = i_in_data.ch;
        keep         = 1'b1;
        unique case (i_in_data.op)
            tlcr_pkg::OP_START: begin
                cmd.kind = tlcr_pkg::CMD_START;
            end
            tlcr_pkg::OP_BYTE: begin
                if (i_in_data.ch == tlcr_pkg::CH_TAB) begin
                    cmd.kind = tlcr_pkg::CMD_TAB;
                end else if (i_in_data.ch < tlcr_pkg::CH_SPACE ||
                             i_in_data.ch == tlcr_pkg::CH_DEL) begin
                    cmd.kind     = tlcr_pkg::CMD_CHARS;
                    cmd.chars[0] = tlcr_pkg::CH_CARET;
                    cmd.chars[1] = i_in_data.ch ^ tlcr_pkg::CH_CARET_XOR;
                    cmd.last_idx = 2'd1;
                end else if (i_in_data.ch[7]) begin
                    cmd.kind     = tlcr_pkg::CMD_CHARS;
                    cmd.chars[0] = tlcr_pkg::CH_LT;
                    cmd.chars[1] = tlcr_pkg::hex_digit(i_in_data.ch[7:4]);
                    cmd.chars[2] = tlcr_pkg::hex_digit(i_in_data.ch[3:0] &
                                                       tlcr_pkg::NIBBLE_MASK);
                    cmd.chars[3] = tlcr_pkg::CH_GT;
                    cmd.last_idx = 2'd3;
                end else begin
                    cmd.kind     = tlcr_pkg::CMD_CHARS;
                    cmd.last_idx = 2'd0;
                end
            end
            tlcr_pkg::OP_END: begin
                cmd.kind = tlcr_pkg::CMD_END;
            end
            default: begin
                keep = 1'b0;    // unused op: accepted and dropped
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/tlcr_queue.sv
// Small command queue between the front end and the cell sequencer.
`default_nettype none

module tlcr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tlcr_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output tlcr_pkg::t_cmd      o_cmd
);

    localparam int AW = $clog2(tlcr_pkg::CMD_DEPTH);

    tlcr_pkg::t_cmd r_mem [tlcr_pkg::CMD_DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [AW:0]    r_count;
    logic [AW-1:0]  n_wptr;
    logic [AW-1:0]  n_rptr;
    logic           do_push;
    logic           do_pop;

    assign o_full  = r_count == (AW+1)'(tlcr_pkg::CMD_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    assign n_wptr = (r_wptr == AW'(tlcr_pkg::CMD_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == AW'(tlcr_pkg::CMD_DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= n_wptr;
            end
            if (do_pop) begin
                r_rptr <= n_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tlcr_back.sv
// Cell sequencer: walks each command one cell per cycle when not stalled; holds the cursor.
`default_nettype none

module tlcr_back #(
    parameter int TAB_WIDTH = tlcr_pkg::TAB_WIDTH_DEFAULT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_width,
    input  wire logic           i_q_valid,
    input  wire tlcr_pkg::t_cmd i_q_cmd,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tlcr_pkg::t_out      o_out_data
);

    localparam int PW    = $clog2(TAB_WIDTH);
    localparam int CW    = tlcr_pkg::CUR_W;
    localparam int MCW   = $clog2(tlcr_pkg::MOD_STEPS);
    localparam int RS    = CW + PW;
    localparam int RW    = CW + 2;
    localparam int PRW   = RS + CW;

    localparam logic [PW:0]   TW_C     = (PW+1)'(TAB_WIDTH);
    localparam logic [PW-1:0] PH_LAST  = PW'(TAB_WIDTH - 1);
    localparam logic [MCW-1:0] MOD_END = MCW'(tlcr_pkg::MOD_STEPS - 1);
    // ceil(2^RS / TAB_WIDTH): exact quotient for any CW-bit dividend
    localparam logic [RW-1:0] RECIP    = RW'(((1 << RS) + TAB_WIDTH - 1) / TAB_WIDTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHARS = 6'b000010,
        S_TAB  = 6'b000100,
        S_END  = 6'b001000,
        S_MARK = 6'b010000,
        S_MOD  = 6'b100000
    } t_state;

    t_state                 r_state, n_state;
    logic signed [CW-1:0]   r_cursor, n_cursor;
    logic [PW-1:0]          r_phase, n_phase;
    logic [11:0]            r_tab_base, n_tab_base;
    logic [3:0][7:0]        r_chars, n_chars;
    logic [1:0]             r_last_idx, n_last_idx;
    logic [1:0]             r_idx, n_idx;
    logic [PW-1:0]          r_tab_cnt, n_tab_cnt;
    logic                   r_mark, n_mark;
    logic [MCW-1:0]         r_mod_cnt, n_mod_cnt;
    logic [CW-1:0]          r_quot, n_quot;
    logic                   r_out_valid;
    tlcr_pkg::t_out         r_out_data;

    logic                   can_emit;
    logic                   emit;
    tlcr_pkg::t_out         e_data;
    logic [CW-1:0]          w_ext;
    logic                   ge;
    logic                   vis;
    logic [7:0]             cell_col;
    logic                   sat;
    logic signed [CW-1:0]   adv_cursor;
    logic [PW-1:0]          adv_phase;
    logic [CW:0]            sum_full;
    logic [CW-1:0]          mod_x;
    logic [PRW-1:0]         mod_prod;
    logic [PW-1:0]          quot_low;
    logic [PW-1:0]          rem;

    assign can_emit    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_ext    = {{(CW-8){1'b0}}, i_width};
    assign ge       = $signed(r_cursor) >= $signed(w_ext);
    assign vis      = ge || !r_cursor[CW-1];
    assign cell_col = ge ? i_width - 8'd1 : r_cursor[7:0];

    // the cursor stops at its maximum; tab phase then stands still as well
    assign sat        = r_cursor == tlcr_pkg::CUR_MAX;
    assign adv_cursor = sat ? r_cursor : r_cursor + 1'b1;
    assign adv_phase  = sat ? r_phase : ((r_phase == PH_LAST) ? '0 : r_phase + 1'b1);

    // cursor + tab base is never negative: it starts at zero on a line start
    assign sum_full = {r_cursor[CW-1], r_cursor} + {{(CW-11){1'b0}}, r_tab_base};
    assign mod_x    = sum_full[CW-1:0];
    assign mod_prod = PRW'(mod_x) * PRW'(RECIP);

    // remainder is below 2^PW, so only the low bits of x - q*TAB_WIDTH matter
    assign quot_low = r_quot[PW-1:0] * TW_C[PW-1:0];
    assign rem      = mod_x[PW-1:0] - quot_low;

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_phase    = r_phase;
        n_tab_base = r_tab_base;
        n_chars    = r_chars;
        n_last_idx = r_last_idx;
        n_idx      = r_idx;
        n_tab_cnt  = r_tab_cnt;
        n_mark     = r_mark;
        n_mod_cnt  = r_mod_cnt;
        n_quot     = r_quot;
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        e_data     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_cmd.kind)
                        tlcr_pkg::CMD_START: begin
                            n_cursor   = '0 - {{(CW-12){1'b0}}, i_q_cmd.offset};
                            n_tab_base = i_q_cmd.offset;
                            n_phase    = '0;
                        end
                        tlcr_pkg::CMD_CHARS: begin
                            n_chars    = i_q_cmd.chars;
                            n_last_idx = ge ? 2'd0 : i_q_cmd.last_idx;
                            n_idx      = 2'd0;
                            n_state    = S_CHARS;
                        end
                        tlcr_pkg::CMD_TAB: begin
                            // past the row end a tab is a single marker
                            n_last_idx = 2'd0;
                            n_idx      = 2'd0;
                            n_tab_cnt  = '0;
                            n_state    = ge ? S_CHARS : S_TAB;
                        end
                        tlcr_pkg::CMD_END: begin
                            n_mark  = i_q_cmd.mark;
                            n_state = S_END;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHARS: begin
                if (!vis || can_emit) begin
                    emit             = vis;
                    e_data.kind      = tlcr_pkg::KIND_CELL;
                    e_data.column    = cell_col;
                    e_data.cell_char = ge ? tlcr_pkg::CH_DOLLAR : r_chars[r_idx];
                    e_data.last      = r_idx == r_last_idx;
                    n_cursor         = adv_cursor;
                    n_phase          = adv_phase;
                    n_idx            = r_idx + 2'd1;
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TAB: begin
                if (!vis || can_emit) begin
                    emit             = vis;
                    e_data.kind      = tlcr_pkg::KIND_CELL;
                    e_data.column    = cell_col;
                    e_data.cell_char = ge ? tlcr_pkg::CH_DOLLAR : tlcr_pkg::CH_SPACE;
                    e_data.last      = (adv_phase == '0) || (r_tab_cnt == PH_LAST);
                    n_cursor         = adv_cursor;
                    n_phase          = adv_phase;
                    n_tab_cnt        = r_tab_cnt + 1'b1;
                    if (e_data.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_END: begin
                if (!ge) begin
                    if (can_emit) begin
                        emit             = 1'b1;
                        e_data.kind      = tlcr_pkg::KIND_FILL;
                        e_data.column    = r_cursor[CW-1] ? 8'd0 : r_cursor[7:0];
                        e_data.cell_char = tlcr_pkg::CH_SPACE;
                        e_data.last      = !r_mark;
                        n_cursor         = w_ext;
                        n_mod_cnt        = '0;
                        n_state          = r_mark ? S_MARK : S_MOD;
                    end
                end else begin
                    n_mod_cnt = '0;
                    n_state   = r_mark ? S_MARK : S_MOD;
                end
            end
            S_MARK: begin
                if (can_emit) begin
                    emit             = 1'b1;
                    e_data.kind      = tlcr_pkg::KIND_CELL;
                    e_data.column    = 8'd0;
                    e_data.cell_char = tlcr_pkg::CH_DOLLAR;
                    e_data.last      = 1'b1;
                    n_mod_cnt        = '0;
                    n_state          = S_MOD;
                end
            end
            S_MOD: begin
                // re-derive the tab phase once the cursor stands at or past the row end:
                // quotient by reciprocal multiply first, remainder next cycle
                if (r_mod_cnt == MOD_END) begin
                    n_phase   = rem;
                    n_mod_cnt = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_quot    = mod_prod[RS +: CW];
                    n_mod_cnt = r_mod_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_phase     <= '0;
            r_tab_base  <= '0;
            r_idx       <= '0;
            r_tab_cnt   <= '0;
            r_mod_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_phase    <= n_phase;
            r_tab_base <= n_tab_base;
            r_idx      <= n_idx;
            r_tab_cnt  <= n_tab_cnt;
            r_mod_cnt  <= n_mod_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chars    <= n_chars;
        r_last_idx <= n_last_idx;
        r_mark     <= n_mark;
        r_quot     <= n_quot;
        if (emit) begin
            r_out_data <= e_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/text_line_cell_renderer.sv
// Top level of the text line cell renderer: column register, front end, queue, sequencer.
`default_nettype none

// Turns a stream of line items into cell writes for one screen row. A start
// item places the cursor at minus its scroll offset; each text byte gives one
// cell (printable), two (caret notation), four (<HH>), or up to TAB_WIDTH
// spaces (tab); an end item gives a space fill to the row end and an optional
// '$' in column 0. Cells left of column 0 are dropped and cells past the row
// end become '$' in the last column. The cell sequencer produces one result
// per cycle while the output is not stalled and takes each command from the
// two-entry queue in its idle state; an end line gives its fill and optional
// marker, then recovers the tab phase. The front end keeps accepting items
// while the queue has room, and a result waits in the output register
// without stopping the sequencer from taking its next command. The user must
// write the column register through the config channel only while the block
// is idle; the block itself does not enforce this.
module text_line_cell_renderer #(
    parameter int TAB_WIDTH = tlcr_pkg::TAB_WIDTH_DEFAULT
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire tlcr_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output tlcr_pkg::t_out      o_out_data,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_data
);

    logic [7:0]     r_columns;
    logic [7:0]     width;
    logic           q_full;
    logic           q_push;
    logic           q_valid;
    logic           q_pop;
    tlcr_pkg::t_cmd push_cmd;
    tlcr_pkg::t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;
    assign width       = (r_columns < 8'd2) ? 8'd2 : r_columns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 8'(tlcr_pkg::COLUMNS_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_columns <= i_cfg_data;
        end
    end

    tlcr_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    tlcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd)
    );

    tlcr_back #(
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (width),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_text_line_cell_renderer.sv
// Self-checking testbench of the text line cell renderer: directed table, random lines, checks.
`timescale 1ns / 100ps

module tb_text_line_cell_renderer;
    import tlcr_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         TAB_W       = TAB_WIDTH_DEFAULT;
    localparam int         CURSOR_TOP  = int'(CUR_MAX);
    localparam int         DRAIN_WAIT  = 16;
    localparam int         QUIET_LIMIT = 3000;
    localparam int         PHASE_ITEMS = 12;
    localparam int         PRINT_MAX   = 40;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in        i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [7:0] i_cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out       o_out_data;
    logic       o_cfg_ready;

    text_line_cell_renderer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // renderer state as the testbench sees it
    int         vcursor    = 0;
    int         tab_origin = 0;
    logic [7:0] row_cols   = COLUMNS_RESET;

    t_out cells_due[$];    // cell writes still to come, oldest first
    t_out item_cells[$];   // cell writes of the item just rendered

    // directed table
    t_in  dir_items[$];
    int   dir_ntyped[$];   // -1: take the predicted cells
    t_out dir_typed[$];

    int  err_count     = 0;
    int  items_sent    = 0;
    int  cells_checked = 0;
    int  settings_used = 1;
    int  quiet_cycles  = 0;
    int  stall_left    = 0;
    bit  in_gap_on     = 1'b1;
    bit  stall_on      = 1'b1;

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_MAX) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    // ---------------- cell predictor ----------------
    function automatic int row_width();
        return (row_cols < 8'd2) ? 2 : int'(row_cols);
    endfunction

    function automatic void step_cursor();
        if (vcursor < CURSOR_TOP) begin
            vcursor++;
        end
    endfunction

    function automatic void emit_cell(input logic kind, input int col, input logic [7:0] chr);
        t_out c;
        c.kind      = kind;
        c.column    = 8'(col);
        c.cell_char = chr;
        c.last      = 1'b0;
        item_cells.push_back(c);
    endfunction

    function automatic void place_char(input logic [7:0] chr);
        int w;
        w = row_width();
        if (vcursor >= w) begin
            step_cursor();
            emit_cell(KIND_CELL, w - 1, CH_DOLLAR);
        end else begin
            if (vcursor >= 0) begin
                emit_cell(KIND_CELL, vcursor, chr);
            end
            step_cursor();
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h41 + 8'(nib) - 8'd10;
    endfunction

    function automatic bit on_tab_stop();
        int r;
        r = (vcursor + tab_origin) % TAB_W;
        if (r < 0) begin
            r += TAB_W;
        end
        return r == 0;
    endfunction

    function automatic void render_item(input t_in it);
        int w;
        int k;
        bit stop;
        item_cells.delete();
        w = row_width();
        case (it.op)
            OP_START: begin
                vcursor    = -int'(it.scroll_offset);
                tab_origin = int'(it.scroll_offset);
            end
            OP_BYTE: begin
                if (vcursor >= w) begin
                    place_char(CH_DOLLAR);
                end else if (it.ch == CH_TAB) begin
                    stop = 1'b0;
                    for (k = 0; k < TAB_W && !stop; k++) begin
                        place_char(CH_SPACE);
                        stop = on_tab_stop();
                    end
                end else if (it.ch < CH_SPACE || it.ch == CH_DEL) begin
                    place_char(CH_CARET);
                    place_char(it.ch ^ CH_CARET_XOR);
                end else if (it.ch[7]) begin
                    place_char(CH_LT);
                    place_char(hex_char(it.ch[7:4]));
                    place_char(hex_char(it.ch[3:0] & NIBBLE_MASK));
                    place_char(CH_GT);
                end else begin
                    place_char(it.ch);
                end
            end
            OP_END: begin
                if (vcursor < w) begin
                    emit_cell(KIND_FILL, (vcursor < 0) ? 0 : vcursor, CH_SPACE);
                    vcursor = w;
                end
                if (it.mark_left) begin
                    emit_cell(KIND_CELL, 0, CH_DOLLAR);
                end
            end
            default: ;
        endcase
        if (item_cells.size() > 0) begin
            item_cells[item_cells.size() - 1].last = 1'b1;
        end
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void add_row(input logic [1:0] op, input logic [7:0] ch,
                                    input logic [11:0] off, input logic mark, input int ntyped);
        t_in it;
        it.op            = op;
        it.ch            = ch;
        it.scroll_offset = off;
        it.mark_left     = mark;
        dir_items.push_back(it);
        dir_ntyped.push_back(ntyped);
    endfunction

    function automatic void add_typed(input logic kind, input logic [7:0] col,
                                      input logic [7:0] chr, input logic last);
        t_out c;
        c.kind      = kind;
        c.column    = col;
        c.cell_char = chr;
        c.last      = last;
        dir_typed.push_back(c);
    endfunction

    function automatic t_in random_fields();
        t_in it;
        it.op            = 2'($urandom_range(3));
        it.ch            = 8'($urandom_range(255));
        it.scroll_offset = 12'($urandom_range(4095));
        it.mark_left     = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        int c;
        r = $urandom_range(99);
        if (r < 55) begin
            return 8'($urandom_range(8'h7E, 8'h20));
        end else if (r < 67) begin
            c = $urandom_range(32);
            return (c == 32) ? CH_DEL : 8'(c);
        end else if (r < 82) begin
            return 8'($urandom_range(8'hFF, 8'h80));
        end
        return CH_TAB;
    endfunction

    function automatic logic [11:0] pick_offset();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return 12'($urandom_range(15));
        end else if (r < 90) begin
            return 12'($urandom_range(300, 16));
        end
        return 12'($urandom_range(4095));
    endfunction

    // one input beat; expectations are queued at the accepting edge
    task automatic send_item(input t_in it, input int ntyped);
        int gap;
        int k;
        int r;
        gap = 0;
        if (in_gap_on) begin
            r = $urandom_range(99);
            if (r >= 93) begin
                gap = $urandom_range(30, 8);
            end else if (r >= 55) begin
                gap = $urandom_range(3, 1);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        render_item(it);
        if (ntyped < 0) begin
            foreach (item_cells[k]) cells_due.push_back(item_cells[k]);
        end else begin
            for (k = 0; k < ntyped; k++) cells_due.push_back(dir_typed.pop_front());
        end
        if (it.op != OP_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (cells_due.size() != 0) @(posedge i_clk);
        // an end line keeps the sequencer busy past its last cell, recovering the tab phase
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_columns(input logic [7:0] cols);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cols;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        row_cols = cols;
        settings_used++;
        in_gap_on = ($urandom_range(3) != 0);
        stall_on  = ($urandom_range(3) != 0);
    endtask

    // mostly whole lines with random content, some stray or broken items
    task automatic run_random(input int quota);
        int   first;
        int   nbytes;
        int   k;
        t_in  it;
        first = items_sent;
        while (items_sent - first < quota) begin
            if ($urandom_range(9) == 0) begin
                send_item(random_fields(), -1);
            end else begin
                it = random_fields();
                it.op = OP_START;
                it.scroll_offset = pick_offset();
                send_item(it, -1);
                nbytes = $urandom_range(12);
                for (k = 0; k < nbytes; k++) begin
                    it = random_fields();
                    it.op = OP_BYTE;
                    it.ch = pick_text_byte();
                    send_item(it, -1);
                end
                if ($urandom_range(7) != 0) begin
                    it = random_fields();
                    it.op = OP_END;
                    send_item(it, -1);
                end
            end
        end
    endtask

    // ---------------- result checker and output stalls ----------------
    always @(posedge i_clk) begin : cell_check
        t_out want;
        int   r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cells_due.size() == 0) begin
                report_mismatch($sformatf("unexpected cell kind %0d col %0d char %02h",
                                          o_out_data.kind, o_out_data.column,
                                          o_out_data.cell_char));
            end else begin
                want = cells_due.pop_front();
                cells_checked++;
                if (o_out_data.kind !== want.kind)
                    report_mismatch($sformatf("kind %b, want %b", o_out_data.kind, want.kind));
                if (o_out_data.column !== want.column)
                    report_mismatch($sformatf("column %0d, want %0d",
                                              o_out_data.column, want.column));
                if (o_out_data.cell_char !== want.cell_char)
                    report_mismatch($sformatf("char %02h, want %02h at col %0d",
                                              o_out_data.cell_char, want.cell_char,
                                              want.column));
                if (o_out_data.last !== want.last)
                    report_mismatch($sformatf("last %b, want %b at col %0d",
                                              o_out_data.last, want.last, want.column));
            end
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (stall_on) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    stall_left = $urandom_range(3, 1);
                end else if (r < 17) begin
                    stall_left = $urandom_range(40, 10);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d cells pending",
                     QUIET_LIMIT, cells_due.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- sequence ----------------
    initial begin : main_seq
        int  r;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset width 80, cursor 0, tab base 0
        add_row(OP_BYTE, 8'h41, 12'h000, 1'b0, 1);             // 'A'
        add_typed(KIND_CELL, 8'd0, 8'h41, 1'b1);
        add_row(OP_BYTE, 8'h00, 12'hFFF, 1'b1, 2);             // NUL -> ^@
        add_typed(KIND_CELL, 8'd1, CH_CARET, 1'b0);
        add_typed(KIND_CELL, 8'd2, 8'h40, 1'b1);
        add_row(OP_BYTE, CH_DEL, 12'h000, 1'b0, 2);            // DEL -> ^?
        add_typed(KIND_CELL, 8'd3, CH_CARET, 1'b0);
        add_typed(KIND_CELL, 8'd4, 8'h3F, 1'b1);
        add_row(OP_BYTE, 8'hFF, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, 8'h80, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, CH_TAB, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, 8'h7E, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, CH_SPACE, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, 8'h1F, 12'h000, 1'b0, -1);
        add_row(OP_UNUSED, 8'hFF, 12'hFFF, 1'b1, 0);           // ignored op
        add_row(OP_END, 8'h00, 12'h000, 1'b1, -1);
        add_row(OP_BYTE, 8'h78, 12'h000, 1'b0, 1);             // past the row end
        add_typed(KIND_CELL, 8'd79, CH_DOLLAR, 1'b1);
        add_row(OP_BYTE, CH_TAB, 12'h000, 1'b0, 1);            // tab past the row end
        add_typed(KIND_CELL, 8'd79, CH_DOLLAR, 1'b1);
        add_row(OP_END, 8'h00, 12'h000, 1'b0, 0);              // row already full
        add_row(OP_END, 8'h00, 12'h000, 1'b1, 1);
        add_typed(KIND_CELL, 8'd0, CH_DOLLAR, 1'b1);
        add_row(OP_START, 8'h00, 12'hFFF, 1'b0, 0);            // deepest scroll
        add_row(OP_BYTE, CH_TAB, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, 8'h80, 12'h000, 1'b0, -1);
        add_row(OP_END, 8'h00, 12'h000, 1'b0, 1);              // fill start clamps to 0
        add_typed(KIND_FILL, 8'd0, CH_SPACE, 1'b1);
        add_row(OP_START, 8'hFF, 12'h005, 1'b1, 0);
        add_row(OP_BYTE, 8'h85, 12'h000, 1'b0, -1);            // hex lies wholly left of column 0
        add_row(OP_BYTE, CH_TAB, 12'h000, 1'b0, -1);
        add_row(OP_BYTE, 8'h01, 12'h000, 1'b0, -1);
        add_row(OP_END, 8'h00, 12'h000, 1'b1, -1);

        foreach (dir_items[k]) send_item(dir_items[k], dir_ntyped[k]);

        write_columns(8'd2);
        run_random(PHASE_ITEMS);
        write_columns(8'd255);
        run_random(PHASE_ITEMS);
        write_columns(8'd1);                                   // narrow width acts as 2
        run_random(PHASE_ITEMS);
        write_columns(8'd37);
        run_random(PHASE_ITEMS);
        r = $urandom_range(254, 3);
        write_columns(8'(r));
        run_random(PHASE_ITEMS);

        wait_drained();
        $display("covered %0d line items over %0d column settings, incl. scrolled rows",
                 items_sent, settings_used);
        $display("checked %0d cell writes, %0d mismatches", cells_checked, err_count);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tlcr_pkg.sv
hw/rtl/tlcr_front.sv
hw/rtl/tlcr_queue.sv
hw/rtl/tlcr_back.sv
hw/rtl/text_line_cell_renderer.sv
tb/sv/tb_text_line_cell_renderer.sv
